// File: hw/rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// File: hw/rtl/minv_pkg.sv
// ----------------------------------------------------------------------------
// minv_pkg
// Types and fixed constants of the cofactor matrix inverse block.
// ----------------------------------------------------------------------------
package minv_pkg;

    // Word and register widths fixed by the interface.
    localparam int ELEM_W  = 32;
    localparam int ORDER_W = 3;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register index of the order register.
    localparam logic REG_ORDER = 1'b0;

    // Order after reset.
    localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd4;

    // Saturation bounds of a Q16.16 word.
    localparam logic [ELEM_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [ELEM_W-1:0] Q_MIN = 32'h8000_0000;

    // Sequencer states.
    typedef enum logic [8:0] {
        S_LOAD  = 9'b000000001,
        S_CHECK = 9'b000000010,
        S_MUL   = 9'b000000100,
        S_ACC   = 9'b000001000,
        S_NEXT  = 9'b000010000,
        S_DONE  = 9'b000100000,
        S_DIV   = 9'b001000000,
        S_RND   = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

endpackage

// File: hw/rtl/matrix_inverse_by_cofactors.sv
// ----------------------------------------------------------------------------
// matrix_inverse_by_cofactors
// Inverse of a square Q16.16 matrix as adjugate over determinant.
// ----------------------------------------------------------------------------
// Usage: the order n is set through the APB port (register 0, reset value 4;
// 0 acts as 1, values above MAX_ORDER act as MAX_ORDER). Writing it drops a
// partly loaded matrix. The input channel takes n*n words in row-major order,
// one per cycle. After the last word the block drops ready and computes the
// determinant, then for each inverse element a cofactor and a rounded
// division. A zero determinant gives one word flagged singular and last.
// Otherwise n*n words come out in row-major order, the final one with last.
// Determinants and cofactors are sums over permutations formed by a digit
// counter that walks all k^k column tuples; each term is built on one
// 32x32 multiplier, one limb per cycle (MAX_ORDER limbs per factor).
// Each quotient comes from a bit-serial restoring divider.
// A stalled receiver holds the block in its output state with the word
// unchanged. Reset empties the load count and sets the order to 4.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module matrix_inverse_by_cofactors #(
    parameter int MAX_ORDER = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // APB configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [minv_pkg::PADDR_W-1:0]         paddr,
    input  logic [minv_pkg::PDATA_W-1:0]         pwdata,
    output logic [minv_pkg::PDATA_W-1:0]         prdata,
    output logic                                 pready,
    // input words
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [minv_pkg::ELEM_W-1:0]   i_element,
    // result words
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [minv_pkg::ELEM_W-1:0]   o_inverse_value,
    output logic                                 o_singular,
    output logic                                 o_last
);
    import minv_pkg::*;

    localparam int STORE_D = MAX_ORDER * MAX_ORDER;
    localparam int AW      = (STORE_D > 1) ? $clog2(STORE_D) : 1;
    localparam int LW      = $clog2(STORE_D + 1);
    localparam int CW      = $clog2(MAX_ORDER + 1);
    localparam int DW      = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int PL      = MAX_ORDER;
    localparam int PW      = ELEM_W * PL;
    localparam int LIW     = (PL > 1) ? $clog2(PL) : 1;
    localparam int ACC_W   = ELEM_W * (MAX_ORDER + 2);
    localparam int DCW     = $clog2(ACC_W + 1);

    // Registers
    t_state                r_state;
    logic [ORDER_W-1:0]    r_order;
    logic [LW-1:0]         r_load_cnt;
    logic [ELEM_W-1:0]     r_store [STORE_D];
    logic                  r_is_cof;
    logic [CW-1:0]         r_k;
    logic [DW-1:0]         r_skip_r;
    logic [DW-1:0]         r_skip_c;
    logic [DW-1:0]         r_dig [MAX_ORDER];
    logic [DW-1:0]         r_pos;
    logic [LIW-1:0]        r_limb;
    logic [PW-1:0]         r_prod;
    logic [ELEM_W-1:0]     r_carry;
    logic                  r_sgn;
    logic [ACC_W-1:0]      r_acc;
    logic [ACC_W-1:0]      r_det;
    logic                  r_dneg;
    logic                  r_rneg;
    logic [DW-1:0]         r_oi;
    logic [DW-1:0]         r_oj;
    logic [ACC_W-1:0]      r_num;
    logic [ACC_W-1:0]      r_rem;
    logic [ACC_W-1:0]      r_quo;
    logic [DCW-1:0]        r_cnt;
    logic [ELEM_W-1:0]     r_out_val;
    logic                  r_out_sing;
    logic                  r_out_last;

    // Combinational helpers
    logic [CW-1:0]         ord_use;
    logic [LW-1:0]         total;
    logic                  cfg_we;
    logic                  in_acc;
    logic                  is_perm;
    logic                  parity;
    logic [DW-1:0]         nxt_dig [MAX_ORDER];
    logic                  wrap;
    logic [AW-1:0]         rd_addr;
    logic [ELEM_W-1:0]     rd_elem;
    logic [ELEM_W-1:0]     rd_mag;
    logic [2*ELEM_W-1:0]   mul_out;
    logic [ACC_W-1:0]      acc_mag;
    logic [ACC_W:0]        rem_sh;
    logic [ACC_W:0]        rem_diff;
    logic                  rem_ge;
    logic [ACC_W:0]        rnd_sh;
    logic [ACC_W-1:0]      q_rnd;
    logic                  q_high;
    logic [ELEM_W-1:0]     q_sat;
    logic [DW-1:0]         ni;
    logic [DW-1:0]         nj;
    logic                  last_ij;

    // Order in use, clamped to the supported range.
    always_comb begin
        int t;
        if (r_order == '0) begin
            ord_use = CW'(1);
        end else if (int'(r_order) > MAX_ORDER) begin
            ord_use = CW'(MAX_ORDER);
        end else begin
            ord_use = CW'(r_order);
        end
        t = int'(ord_use) * int'(ord_use);
        total = LW'(t);
    end

    // Configuration access; the port never waits.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_ORDER);
    assign prdata = (paddr[2] == REG_ORDER) ? PDATA_W'(r_order) : '0;

    assign o_ready = (r_state == S_LOAD);
    assign in_acc  = i_valid && o_ready;
    assign o_valid = (r_state == S_OUT);
    assign o_inverse_value = r_out_val;
    assign o_singular      = r_out_sing;
    assign o_last          = r_out_last;

    // Permutation test and sign of the current column tuple.
    always_comb begin
        is_perm = 1'b1;
        parity  = 1'b0;
        for (int a = 0; a < MAX_ORDER; a++) begin
            for (int b = 0; b < MAX_ORDER; b++) begin
                if (a < b && b < int'(r_k)) begin
                    if (r_dig[a] == r_dig[b]) is_perm = 1'b0;
                    if (r_dig[a] > r_dig[b]) parity = ~parity;
                end
            end
        end
    end

    // Next column tuple, counted in base k.
    always_comb begin
        logic c;
        c = 1'b1;
        for (int t = 0; t < MAX_ORDER; t++) begin
            nxt_dig[t] = r_dig[t];
            if (t < int'(r_k) && c) begin
                if (int'(r_dig[t]) == int'(r_k) - 1) begin
                    nxt_dig[t] = '0;
                end else begin
                    nxt_dig[t] = r_dig[t] + 1'b1;
                    c = 1'b0;
                end
            end
        end
        wrap = c;
    end

    // Element of the current factor, skipping the removed row and column.
    always_comb begin
        int row;
        int col;
        int a;
        row = int'(r_pos);
        col = int'(r_dig[r_pos]);
        if (r_is_cof && r_pos >= r_skip_r) row = row + 1;
        if (r_is_cof && r_dig[r_pos] >= r_skip_c) col = col + 1;
        a = row * int'(ord_use) + col;
        rd_addr = AW'(a);
        rd_elem = r_store[rd_addr];
        rd_mag  = rd_elem[ELEM_W-1] ? (ELEM_W'(0) - rd_elem) : rd_elem;
    end

    // Shared multiplier: one limb of the running product per cycle.
    assign mul_out = {{ELEM_W{1'b0}}, r_prod[ELEM_W*r_limb +: ELEM_W]}
                   * {{ELEM_W{1'b0}}, rd_mag}
                   + {{ELEM_W{1'b0}}, r_carry};

    assign acc_mag = r_acc[ACC_W-1] ? (ACC_W'(0) - r_acc) : r_acc;

    // Restoring divider step.
    assign rem_sh   = {r_rem, r_num[ACC_W-1]};
    assign rem_diff = rem_sh - {1'b0, r_det};
    assign rem_ge   = (rem_sh >= {1'b0, r_det});

    // Round to nearest, ties away from zero, then saturate.
    always_comb begin
        rnd_sh = {r_rem, 1'b0};
        q_rnd  = r_quo + ACC_W'(rnd_sh >= {1'b0, r_det});
        q_high = |q_rnd[ACC_W-1:ELEM_W];
        if (!r_rneg) begin
            q_sat = (q_high || q_rnd[ELEM_W-1]) ? Q_MAX : q_rnd[ELEM_W-1:0];
        end else begin
            q_sat = (q_high || q_rnd[ELEM_W-1:0] > Q_MIN) ? Q_MIN
                                                          : (ELEM_W'(0) - q_rnd[ELEM_W-1:0]);
        end
    end

    // Next output position.
    always_comb begin
        last_ij = (int'(r_oi) == int'(ord_use) - 1) && (int'(r_oj) == int'(ord_use) - 1);
        if (int'(r_oj) == int'(ord_use) - 1) begin
            nj = '0;
            ni = r_oi + 1'b1;
        end else begin
            nj = r_oj + 1'b1;
            ni = r_oi;
        end
    end

    // Matrix store: written while loading.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_store[r_load_cnt[AW-1:0]] <= i_element;
        end
    end

    // Sequencer and datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_order    <= ORDER_RESET;
            r_load_cnt <= '0;
        end else begin
            if (cfg_we) begin
                r_order    <= pwdata[ORDER_W-1:0];
                r_load_cnt <= '0;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (in_acc && !cfg_we) begin
                        if (r_load_cnt + 1'b1 == total) begin
                            r_load_cnt <= '0;
                            r_is_cof   <= 1'b0;
                            r_k        <= ord_use;
                            r_acc      <= '0;
                            for (int t = 0; t < MAX_ORDER; t++) r_dig[t] <= '0;
                            r_state    <= S_CHECK;
                        end else begin
                            r_load_cnt <= r_load_cnt + 1'b1;
                        end
                    end
                end
                S_CHECK: begin
                    if (is_perm) begin
                        r_prod  <= PW'(1);
                        r_sgn   <= parity;
                        r_pos   <= '0;
                        r_limb  <= '0;
                        r_carry <= '0;
                        r_state <= (r_k == '0) ? S_ACC : S_MUL;
                    end else begin
                        r_state <= S_NEXT;
                    end
                end
                S_MUL: begin
                    r_prod[ELEM_W*r_limb +: ELEM_W] <= mul_out[ELEM_W-1:0];
                    if (int'(r_limb) == PL - 1) begin
                        r_limb  <= '0;
                        r_carry <= '0;
                        r_sgn   <= r_sgn ^ rd_elem[ELEM_W-1];
                        if (int'(r_pos) == int'(r_k) - 1) begin
                            r_state <= S_ACC;
                        end else begin
                            r_pos <= r_pos + 1'b1;
                        end
                    end else begin
                        r_limb  <= r_limb + 1'b1;
                        r_carry <= mul_out[2*ELEM_W-1:ELEM_W];
                    end
                end
                S_ACC: begin
                    if (r_sgn) begin
                        r_acc <= r_acc - ACC_W'(r_prod);
                    end else begin
                        r_acc <= r_acc + ACC_W'(r_prod);
                    end
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    if (wrap) begin
                        r_state <= S_DONE;
                    end else begin
                        for (int t = 0; t < MAX_ORDER; t++) r_dig[t] <= nxt_dig[t];
                        r_state <= S_CHECK;
                    end
                end
                S_DONE: begin
                    if (!r_is_cof) begin
                        if (r_acc == '0) begin
                            r_out_val  <= '0;
                            r_out_sing <= 1'b1;
                            r_out_last <= 1'b1;
                            r_state    <= S_OUT;
                        end else begin
                            // Start the cofactor of element (0,0).
                            r_det    <= acc_mag;
                            r_dneg   <= r_acc[ACC_W-1];
                            r_oi     <= '0;
                            r_oj     <= '0;
                            r_is_cof <= 1'b1;
                            r_k      <= ord_use - 1'b1;
                            r_skip_r <= '0;
                            r_skip_c <= '0;
                            r_acc    <= '0;
                            for (int t = 0; t < MAX_ORDER; t++) r_dig[t] <= '0;
                            r_state  <= S_CHECK;
                        end
                    end else begin
                        r_rneg  <= r_acc[ACC_W-1] ^ r_oi[0] ^ r_oj[0] ^ r_dneg;
                        r_num   <= {acc_mag[ACC_W-ELEM_W-1:0], {ELEM_W{1'b0}}};
                        r_rem   <= '0;
                        r_quo   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem   <= rem_ge ? rem_diff[ACC_W-1:0] : rem_sh[ACC_W-1:0];
                    r_quo   <= {r_quo[ACC_W-2:0], rem_ge};
                    r_num   <= {r_num[ACC_W-2:0], 1'b0};
                    r_cnt   <= r_cnt + 1'b1;
                    if (int'(r_cnt) == ACC_W - 1) begin
                        r_state <= S_RND;
                    end
                end
                S_RND: begin
                    r_out_val  <= q_sat;
                    r_out_sing <= 1'b0;
                    r_out_last <= last_ij;
                    r_state    <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) begin
                        if (r_out_last) begin
                            r_state <= S_LOAD;
                        end else begin
                            // Cofactor of element (j,i) gives inverse word (i,j).
                            r_oi     <= ni;
                            r_oj     <= nj;
                            r_skip_r <= nj;
                            r_skip_c <= ni;
                            r_acc    <= '0;
                            for (int t = 0; t < MAX_ORDER; t++) r_dig[t] <= '0;
                            r_state  <= S_CHECK;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    // Checks on the sequencing.
    `ASSERT_IMP(a_ready_excl, i_clk, i_rst_n, o_ready, !o_valid)
    `ASSERT_IMP(a_sing_last, i_clk, i_rst_n, o_valid && o_singular, o_last && (o_inverse_value == '0))
    `ASSERT_NXT(a_full_busy, i_clk, i_rst_n, in_acc && !cfg_we && (r_load_cnt + 1'b1 == total), !o_ready)
    `ASSERT_IMP(a_div_nonzero, i_clk, i_rst_n, r_state == S_DIV, r_det != '0)

endmodule
